[hw/rtl/vtsp_pkg.sv]
package vtsp_pkg;

  localparam int unsigned FracBitsDef = 16;
  localparam int unsigned NumCoeff    = 12;
  localparam int unsigned QDepth      = 4;
  localparam int unsigned QCntW       = $clog2(QDepth + 1);
  localparam int unsigned QPtrW       = $clog2(QDepth);
  // quotient bits resolved one per stage; larger quotients always saturate
  localparam int unsigned DivSteps    = 34;
  localparam int unsigned DivLat      = DivSteps + 2;
  localparam int unsigned InDataW     = 136;
  localparam int unsigned OutDataW    = 64;

  typedef enum logic {
    OP_LOAD  = 1'b0,
    OP_POINT = 1'b1
  } op_e;

  typedef enum logic [1:0] {
    KIND_LOAD,
    KIND_POINT,
    KIND_DROP
  } kind_e;

  typedef enum logic [1:0] {
    REG_ORIGIN_X,
    REG_ORIGIN_Y,
    REG_EXTENT_W,
    REG_EXTENT_H
  } reg_e;

  typedef struct packed {
    logic        is_point;
    logic [3:0]  slot;
    logic [31:0] value;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
  } item_t;

  typedef struct packed {
    logic signed [31:0] origin_x;
    logic signed [31:0] origin_y;
    logic signed [31:0] extent_w;
    logic signed [31:0] extent_h;
  } cfg_t;

  typedef struct packed {
    logic             full;
    logic             empty;
    logic [QCntW-1:0] count;
  } qstat_t;

  function automatic logic ovf32(input logic signed [65:0] v);
    return (v > 66'sd2147483647) || (v < -66'sd2147483648);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sd2147483647) r = 32'sh7fffffff;
    else if (v < -66'sd2147483648) r = 32'sh80000000;
    else r = v[31:0];
    return r;
  endfunction

endpackage

[hw/rtl/vertex_to_screen_projection.sv]
// projects points to window pixel coordinates, signed fixed point
// s_axis: one beat per item; tuser = operation (0 loads a matrix slot,
//   1 transforms a point); loads give no output beat
// m_axis: one beat per transformed point, tuser = invalid flag
// cfg: write origin/extent registers only while the block is idle
// pipeline: a point's input beat is taken into the queue, then passes the point,
//   products, clip rows and scale product registers, then the
//   one-quotient-bit-per-stage divider (36 stages) with origin add
// throughput: one beat per cycle; every stage holds when the output is
//   stalled, the 4-deep input queue keeps taking beats until it fills
// reset: matrix and registers clear to zero, queue and pipeline empty
// a slot index of 12 or more is taken and ignored
module vertex_to_screen_projection import vtsp_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [InDataW-1:0]  s_axis_tdata,  // coeff_index, coeff_value, point_x/y/z
  input  logic                s_axis_tuser,  // operation
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OutDataW-1:0] m_axis_tdata,  // screen_x, screen_y
  output logic                m_axis_tuser,  // invalid
  input  logic                cfg_we_i,
  input  logic [1:0]          cfg_idx_i,
  input  logic [31:0]         cfg_data_i
);

  cfg_t cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '0;
    end else if (cfg_we_i) begin
      case (reg_e'(cfg_idx_i))
        REG_ORIGIN_X: cfg_q.origin_x <= cfg_data_i;
        REG_ORIGIN_Y: cfg_q.origin_y <= cfg_data_i;
        REG_EXTENT_W: cfg_q.extent_w <= cfg_data_i;
        REG_EXTENT_H: cfg_q.extent_h <= cfg_data_i;
        default: ;
      endcase
    end
  end

  kind_e  kind;
  item_t  fr_item, q_item;
  qstat_t qstat;
  logic   push, pop;

  vtsp_front u_front (
    .tdata_i(s_axis_tdata), .tuser_i(s_axis_tuser), .kind_o(kind), .item_o(fr_item)
  );

  assign s_axis_tready = !qstat.full;
  assign push = s_axis_tvalid && s_axis_tready && (kind != KIND_DROP);

  vtsp_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .item_i(fr_item), .pop_i(pop),
    .item_o(q_item), .stat_o(qstat)
  );

  logic signed [31:0] sx, sy;

  vtsp_back #(.FracBits(FracBits)) u_back (
    .clk_i, .rst_ni, .cfg_i(cfg_q), .q_valid_i(!qstat.empty), .item_i(q_item),
    .pop_o(pop), .out_tready_i(m_axis_tready), .out_tvalid_o(m_axis_tvalid),
    .sx_o(sx), .sy_o(sy), .inv_o(m_axis_tuser)
  );

  assign m_axis_tdata = {sy, sx};

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !qstat.full) else $error("queue push while full");

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !qstat.empty) else $error("queue pop while empty");

  a_count_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && !pop) |=> (qstat.count == $past(qstat.count) + 1'b1))
    else $error("queue count did not follow push");

endmodule

[hw/rtl/vtsp_front.sv]
module vtsp_front import vtsp_pkg::*; (
  input  logic [InDataW-1:0] tdata_i,
  input  logic               tuser_i,
  output kind_e              kind_o,
  output item_t              item_o
);

  always_comb begin
    item_o.is_point = (tuser_i == OP_POINT);
    item_o.slot     = tdata_i[3:0];
    item_o.value    = tdata_i[35:4];
    item_o.px       = tdata_i[67:36];
    item_o.py       = tdata_i[99:68];
    item_o.pz       = tdata_i[131:100];
  end

  // loads to slots past the matrix are marked as drops here
  always_comb begin
    case (op_e'(tuser_i))
      OP_LOAD:  kind_o = (tdata_i[3:0] < 4'(NumCoeff)) ? KIND_LOAD : KIND_DROP;
      OP_POINT: kind_o = KIND_POINT;
      default:  kind_o = KIND_DROP;
    endcase
  end

endmodule

[hw/rtl/vtsp_queue.sv]
module vtsp_queue import vtsp_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   push_i,
  input  item_t  item_i,
  input  logic   pop_i,
  output item_t  item_o,
  output qstat_t stat_o
);

  item_t            mem_q [QDepth];
  logic [QPtrW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCntW-1:0] cnt_q, cnt_d;

  always_comb begin
    wr_d  = push_i ? wr_q + 1'b1 : wr_q;
    rd_d  = pop_i ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + QCntW'(push_i) - QCntW'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= item_i;
  end

  assign item_o       = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == QCntW'(QDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign stat_o.count = cnt_q;

endmodule

[hw/rtl/vtsp_div.sv]
module vtsp_div import vtsp_pkg::*; (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic [63:0]        prod_i,
  input  logic [32:0]        dvsr_i,
  input  logic               neg_i,
  input  logic signed [31:0] origin_i,
  output logic signed [31:0] res_o,
  output logic               sat_o
);

  logic [63:0]         rem_q  [DivSteps+1];
  logic [32:0]         dv_q   [DivSteps+1];
  logic [DivSteps-1:0] quo_q  [DivSteps+1];
  logic                big_q  [DivSteps+1];
  logic                neg_q  [DivSteps+1];
  logic signed [31:0]  res_q;
  logic                sat_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rem_q[0] <= prod_i;
      dv_q[0]  <= dvsr_i;
      quo_q[0] <= '0;
      big_q[0] <= ({3'b0, prod_i} >= {dvsr_i, 34'b0});
      neg_q[0] <= neg_i;
    end
  end

  for (genvar k = 1; k <= DivSteps; k++) begin : g_step
    localparam int unsigned Sh = DivSteps - k;
    logic [97:0] trial;
    logic        take;
    assign trial = 98'(dv_q[k-1]) << Sh;
    assign take  = ({34'b0, rem_q[k-1]} >= trial);
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? rem_q[k-1] - trial[63:0] : rem_q[k-1];
        quo_q[k] <= quo_q[k-1] | (DivSteps'(take) << Sh);
        dv_q[k]  <= dv_q[k-1];
        big_q[k] <= big_q[k-1];
        neg_q[k] <= neg_q[k-1];
      end
    end
  end

  logic [34:0]        qe;
  logic signed [36:0] sq;
  logic signed [65:0] sum;

  always_comb begin
    qe  = big_q[DivSteps] ? 35'(1) << DivSteps : {1'b0, quo_q[DivSteps]};
    sq  = neg_q[DivSteps] ? -$signed({2'b0, qe}) : $signed({2'b0, qe});
    sum = 66'(origin_i) + 66'(sq);
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= sat32(sum);
      sat_q <= ovf32(sum);
    end
  end

  assign res_o = res_q;
  assign sat_o = sat_q;

endmodule

[hw/rtl/vtsp_back.sv]
module vtsp_back import vtsp_pkg::*; #(
  parameter int unsigned FracBits = FracBitsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  cfg_t               cfg_i,
  input  logic               q_valid_i,
  input  item_t              item_i,
  output logic               pop_o,
  input  logic               out_tready_i,
  output logic               out_tvalid_o,
  output logic signed [31:0] sx_o,
  output logic signed [31:0] sy_o,
  output logic               inv_o
);

  logic en;
  logic signed [31:0] m_q [NumCoeff];

  assign en    = !out_tvalid_o || out_tready_i;
  assign pop_o = q_valid_i && en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCoeff; i++) m_q[i] <= '0;
    end else if (pop_o && !item_i.is_point) begin
      m_q[item_i.slot] <= item_i.value;
    end
  end

  // stage a: point
  logic va_q;
  logic signed [31:0] p_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      p_q[0] <= item_i.px;
      p_q[1] <= item_i.py;
      p_q[2] <= item_i.pz;
    end
  end

  // stage b: products
  logic vb_q;
  logic signed [63:0] prod_q [9];
  logic signed [31:0] m3_q [3];
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) begin
        m3_q[r] <= m_q[r*4+3];
        for (int c = 0; c < 3; c++) prod_q[r*3+c] <= m_q[r*4+c] * p_q[c];
      end
    end
  end

  // stage c: clip rows, saturated
  logic vc_q, flc_q;
  logic signed [31:0] clip_q [3];
  logic signed [65:0] acc [3];
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      acc[r] = 66'(prod_q[r*3] >>> FracBits) + 66'(prod_q[r*3+1] >>> FracBits)
             + 66'(prod_q[r*3+2] >>> FracBits) + 66'(m3_q[r]);
    end
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int r = 0; r < 3; r++) clip_q[r] <= sat32(acc[r]);
      flc_q <= ovf32(acc[0]) || ovf32(acc[1]) || ovf32(acc[2]);
    end
  end

  // stage d: numerators times extents, divisor
  logic vd_q, fld_q, zd_q, negx_q, negy_q;
  logic [63:0] px_q, py_q;
  logic [32:0] dv_q;
  logic signed [32:0] numx, numy;
  logic [32:0] mnx, mny, mcw;
  logic [31:0] mew, meh;
  logic [64:0] prx, pry;
  always_comb begin
    numx = 33'(clip_q[0]) + 33'(clip_q[2]);
    numy = 33'(clip_q[2]) - 33'(clip_q[1]);
    mnx  = numx[32] ? 33'(-numx) : 33'(numx);
    mny  = numy[32] ? 33'(-numy) : 33'(numy);
    mcw  = clip_q[2][31] ? 33'(-33'(clip_q[2])) : 33'(clip_q[2]);
    mew  = cfg_i.extent_w[31] ? 32'(-cfg_i.extent_w) : 32'(cfg_i.extent_w);
    meh  = cfg_i.extent_h[31] ? 32'(-cfg_i.extent_h) : 32'(cfg_i.extent_h);
    prx  = 65'(mnx) * 65'(mew);
    pry  = 65'(mny) * 65'(meh);
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      fld_q  <= flc_q;
      zd_q   <= (clip_q[2] == '0);
      px_q   <= prx[63:0];
      py_q   <= pry[63:0];
      dv_q   <= {mcw[31:0], 1'b0};
      negx_q <= numx[32] ^ cfg_i.extent_w[31] ^ clip_q[2][31];
      negy_q <= numy[32] ^ cfg_i.extent_h[31] ^ clip_q[2][31];
    end
  end

  logic signed [31:0] rx, ry;
  logic satx, saty;

  vtsp_div u_div_x (
    .clk_i, .en_i(en), .prod_i(px_q), .dvsr_i(dv_q), .neg_i(negx_q),
    .origin_i(cfg_i.origin_x), .res_o(rx), .sat_o(satx)
  );

  vtsp_div u_div_y (
    .clk_i, .en_i(en), .prod_i(py_q), .dvsr_i(dv_q), .neg_i(negy_q),
    .origin_i(cfg_i.origin_y), .res_o(ry), .sat_o(saty)
  );

  logic sv_q [DivLat];
  logic sfl_q [DivLat];
  logic sz_q [DivLat];

  always_ff @(posedge clk_i) begin
    if (en) begin
      sfl_q[0] <= fld_q;
      sz_q[0]  <= zd_q;
      for (int i = 1; i < DivLat; i++) begin
        sfl_q[i] <= sfl_q[i-1];
        sz_q[i]  <= sz_q[i-1];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
      for (int i = 0; i < DivLat; i++) sv_q[i] <= 1'b0;
    end else if (en) begin
      va_q  <= pop_o && item_i.is_point;
      vb_q  <= va_q;
      vc_q  <= vb_q;
      vd_q  <= vc_q;
      sv_q[0] <= vd_q;
      for (int i = 1; i < DivLat; i++) sv_q[i] <= sv_q[i-1];
    end
  end

  assign out_tvalid_o = sv_q[DivLat-1];
  assign sx_o  = sz_q[DivLat-1] ? '0 : rx;
  assign sy_o  = sz_q[DivLat-1] ? '0 : ry;
  assign inv_o = sz_q[DivLat-1] || sfl_q[DivLat-1] || satx || saty;

endmodule

[test/testbench.sv]
`timescale 1ns / 1ps

module testbench;
  import vtsp_pkg::*;

  typedef struct {
    logic signed [31:0] sx;
    logic signed [31:0] sy;
    logic               inv;
  } screen_t;

  typedef struct {
    op_e         op;
    logic [3:0]  slot;
    logic [31:0] value;
    logic [31:0] px;
    logic [31:0] py;
    logic [31:0] pz;
    bit          typed;
    screen_t     res;
  } row_t;

  localparam int unsigned CycleLimit = 600000;
  localparam int unsigned DrainCycles = 60;
  localparam logic [31:0] One = 32'h0001_0000;

  logic                clk_i;
  logic                rst_ni;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata;
  logic                s_axis_tuser;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OutDataW-1:0] m_axis_tdata;
  logic                m_axis_tuser;
  logic                cfg_we_i;
  logic [1:0]          cfg_idx_i;
  logic [31:0]         cfg_data_i;

  vertex_to_screen_projection dut (.*);

  logic signed [31:0] coeff_q [NumCoeff];
  logic signed [31:0] win_q [4];
  screen_t            pending_q [$];
  int unsigned        n_errors, n_points, n_loads, n_flagged, cycles;
  int unsigned        stall_mode;
  row_t               rows [$];

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("[vertex_to_screen_projection] ERROR");
      $finish;
    end
  end

  function automatic logic signed [31:0] sat_q32(input logic signed [127:0] v, inout bit f);
    if (v > 128'sd2147483647) begin
      f = 1'b1;
      return 32'sh7fffffff;
    end
    if (v < -128'sd2147483648) begin
      f = 1'b1;
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  function automatic logic signed [31:0] clip_dot(input int row, input logic signed [31:0] p [3],
                                                   inout bit f);
    longint acc;
    acc = longint'(coeff_q[row*4+3]);
    for (int c = 0; c < 3; c++)
      acc += (longint'(coeff_q[row*4+c]) * longint'(p[c])) >>> FracBitsDef;
    return sat_q32(128'(signed'(acc)), f);
  endfunction

  function automatic logic [127:0] mag(input logic signed [127:0] v);
    return v < 0 ? -v : v;
  endfunction

  function automatic logic signed [31:0] place_px(input logic signed [31:0] org,
      input logic signed [127:0] num, input logic signed [31:0] ext,
      input logic signed [31:0] cw, inout bit f);
    logic [127:0]        q;
    logic signed [127:0] sum;
    bit                  neg;
    q = (mag(num) * mag(128'(ext))) / (2 * mag(128'(cw)));
    neg = ((num < 0) != (ext < 0)) != (cw < 0);
    sum = 128'(org) + (neg ? -$signed(q) : $signed(q));
    return sat_q32(sum, f);
  endfunction

  function automatic screen_t project_point(input logic [31:0] x, y, z);
    logic signed [31:0] p [3];
    logic signed [31:0] cx, cy, cw;
    screen_t r;
    bit f;
    f = 1'b0;
    p[0] = x;
    p[1] = y;
    p[2] = z;
    cx = clip_dot(0, p, f);
    cy = clip_dot(1, p, f);
    cw = clip_dot(2, p, f);
    r.sx = '0;
    r.sy = '0;
    if (cw == 0) begin
      f = 1'b1;
    end else begin
      r.sx = place_px(win_q[REG_ORIGIN_X], 128'(cx) + 128'(cw), win_q[REG_EXTENT_W], cw, f);
      r.sy = place_px(win_q[REG_ORIGIN_Y], 128'(cw) - 128'(cy), win_q[REG_EXTENT_H], cw, f);
    end
    r.inv = f;
    return r;
  endfunction

  // drives one beat and waits for the handshake; tready is sampled at the falling edge
  task automatic send_beat(input op_e op, input logic [3:0] slot, input logic [31:0] value,
                           input logic [31:0] px, py, pz, input bit typed, input screen_t res);
    bit acc;
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= op;
    s_axis_tdata  <= {4'b0, pz, py, px, value, slot};
    do begin
      @(negedge clk_i);
      acc = s_axis_tready;
      @(posedge clk_i);
    end while (!acc);
    if (op == OP_LOAD) begin
      n_loads++;
      if (slot < NumCoeff) coeff_q[slot] = value;
    end else begin
      n_points++;
      pending_q.push_back(typed ? res : project_point(px, py, pz));
    end
  endtask

  task automatic idle_gap(input int n);
    s_axis_tvalid <= 1'b0;
    repeat (n) @(posedge clk_i);
  endtask

  task automatic write_window(input logic [31:0] ox, oy, ew, eh);
    logic [31:0] v [4];
    v = '{ox, oy, ew, eh};
    s_axis_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    @(posedge clk_i);
    idle_gap(DrainCycles);
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= reg_e'(i);
      cfg_data_i <= v[i];
      win_q[i] = v[i];
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
  endtask

  function automatic logic [31:0] rand_q(input int spread);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'h7fffffff;
      2: return 32'h80000000;
      3: return 32'h0;
      default: return 32'($signed($urandom_range(0, 2*spread)) - spread);
    endcase
  endfunction

  // result checker, outputs only change at the rising edge
  always @(negedge clk_i) begin
    screen_t e;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (pending_q.size() == 0) begin
        $display("%0t unexpected beat x=%h y=%h inv=%b", $time,
                 m_axis_tdata[31:0], m_axis_tdata[63:32], m_axis_tuser);
        n_errors++;
      end else begin
        e = pending_q.pop_front();
        if (e.inv) n_flagged++;
        if (m_axis_tdata[31:0] !== e.sx) begin
          $display("%0t screen_x exp %h got %h", $time, e.sx, m_axis_tdata[31:0]);
          n_errors++;
        end
        if (m_axis_tdata[63:32] !== e.sy) begin
          $display("%0t screen_y exp %h got %h", $time, e.sy, m_axis_tdata[63:32]);
          n_errors++;
        end
        if (m_axis_tuser !== e.inv) begin
          $display("%0t invalid exp %b got %b", $time, e.inv, m_axis_tuser);
          n_errors++;
        end
      end
    end
  end

  // receiver stalls: modes of none, sparse, heavy and long blocks
  always @(posedge clk_i) begin
    if ($urandom_range(0, 199) == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 7) != 0);
      2: m_axis_tready <= ($urandom_range(0, 2) == 0);
      default: m_axis_tready <= (cycles[4:3] != 2'b00);
    endcase
  end

  function automatic row_t mk(input op_e op, input logic [3:0] slot, input logic [31:0] value,
                              input logic [31:0] px, py, pz);
    row_t r;
    r.op = op; r.slot = slot; r.value = value;
    r.px = px; r.py = py; r.pz = pz;
    r.typed = 1'b0;
    r.res = '{0, 0, 0};
    return r;
  endfunction

  function automatic row_t mk_typed(input logic [31:0] px, py, pz, input screen_t res);
    row_t r;
    r = mk(OP_POINT, 4'hf, $urandom(), px, py, pz);
    r.typed = 1'b1;
    r.res = res;
    return r;
  endfunction

  initial begin
    screen_t none;
    int burst;
    none = '{0, 0, 0};
    rst_ni = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata = '0;
    s_axis_tuser = 1'b0;
    m_axis_tready = 1'b1;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    stall_mode = 0;
    cycles = 0;
    foreach (coeff_q[i]) coeff_q[i] = '0;
    foreach (win_q[i]) win_q[i] = '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: empty matrix gives zero w, ignored slots, identity, extremes
    rows.push_back(mk_typed(32'h7fffffff, 32'h80000000, 32'h0, '{0, 0, 1}));
    rows.push_back(mk(OP_LOAD, 4'd12, One, 0, 0, 0));
    rows.push_back(mk(OP_LOAD, 4'd15, 32'hffffffff, 0, 0, 0));
    rows.push_back(mk_typed(32'h0, 32'h0, 32'h0, '{0, 0, 1}));
    rows.push_back(mk(OP_LOAD, 4'd11, One, 0, 0, 0));
    rows.push_back(mk(OP_LOAD, 4'd0, One, 0, 0, 0));
    rows.push_back(mk(OP_LOAD, 4'd5, One, 0, 0, 0));
    rows.push_back(mk_typed(32'h0, 32'h0, 32'h0, '{32'h01a40000, 32'h01220000, 0}));
    rows.push_back(mk(OP_POINT, 0, 0, One, 32'hffff0000, 32'h0));
    rows.push_back(mk(OP_POINT, 0, 0, 32'h7fffffff, 32'h80000000, 32'h7fffffff));
    rows.push_back(mk(OP_LOAD, 4'd8, 32'h7fffffff, 0, 0, 0));
    rows.push_back(mk(OP_POINT, 0, 0, 32'h7fffffff, 0, 0));
    rows.push_back(mk(OP_POINT, 0, 0, 32'h80000000, 0, 0));
    rows.push_back(mk(OP_LOAD, 4'd10, 32'h80000000, 0, 0, 0));
    rows.push_back(mk(OP_POINT, 0, 0, 32'h00008000, 32'h00002000, 32'h7fffffff));
    rows.push_back(mk(OP_LOAD, 4'd8, 32'h0, 0, 0, 0));
    rows.push_back(mk(OP_LOAD, 4'd10, 32'h0, 0, 0, 0));
    rows.push_back(mk(OP_LOAD, 4'd11, 32'hffff0000, 0, 0, 0));
    rows.push_back(mk(OP_POINT, 0, 0, 32'h00010000, 32'h00020000, 32'h00030000));
    rows.push_back(mk(OP_LOAD, 4'd3, 32'h7fffffff, 0, 0, 0));
    rows.push_back(mk(OP_POINT, 0, 0, 32'h7fffffff, 0, 0));

    write_window(32'h00640000, 32'h00320000, 32'h02800000, 32'h01e00000);
    foreach (rows[i]) begin
      send_beat(rows[i].op, rows[i].slot, rows[i].value, rows[i].px, rows[i].py, rows[i].pz,
                rows[i].typed, rows[i].res);
      if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 3));
    end

    // random phases, window settings include zero and both extremes
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: write_window(0, 0, 0, 0);
        1: write_window(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000);
        2: write_window(32'h80000000, 32'h7fffffff, 32'h80000000, 32'h7fffffff);
        default: write_window($urandom(), $urandom(), rand_q(32'h04000000),
                              rand_q(32'h04000000));
      endcase
      // fresh moderate matrix so most points land inside the window
      for (int s = 0; s < NumCoeff; s++)
        send_beat(OP_LOAD, 4'(s), (s == 11) ? rand_q(32'h00040000) | 32'h100
                                            : rand_q(32'h00040000),
                  $urandom(), $urandom(), $urandom(), 1'b0, none);
      for (int n = 0; n < 330; n += burst) begin
        burst = $urandom_range(1, 24);
        for (int b = 0; b < burst; b++) begin
          if ($urandom_range(0, 6) == 0)
            send_beat(OP_LOAD, 4'($urandom_range(0, 15)), rand_q(32'h00040000),
                      $urandom(), $urandom(), $urandom(), 1'b0, none);
          else
            send_beat(OP_POINT, 4'($urandom()), $urandom(), rand_q(32'h00a00000),
                      rand_q(32'h00a00000), rand_q(32'h00a00000), 1'b0, none);
        end
        if ($urandom_range(0, 2) != 0) idle_gap($urandom_range(1, 12));
      end
    end

    s_axis_tvalid <= 1'b0;
    wait (pending_q.size() == 0);
    repeat (DrainCycles) @(posedge clk_i);
    $display("points sent %0d, matrix loads %0d, flagged results %0d",
             n_points, n_loads, n_flagged);
    $display("covered zero w, clip and output saturation, ignored slots, six window settings");
    if (n_errors == 0) begin
      $display("[vertex_to_screen_projection] OK");
    end else begin
      $display("[vertex_to_screen_projection] ERROR");
    end
    $finish;
  end

endmodule
